// ===== hw/rtl/feeder_stroke_sequencer_defines.svh =====
// ---------------------------------------------------------------------------
// Feeder stroke sequencer assertion macros
// Shared property wrappers for the sequencer's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef FEEDER_STROKE_SEQUENCER_DEFINES_SVH
`define FEEDER_STROKE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define FSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fss check failed");

// Next-cycle implication, disabled while reset is asserted
`define FSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fss check failed");

`endif

// ===== hw/rtl/fss_pkg.sv =====
// ---------------------------------------------------------------------------
// Feeder stroke sequencer package
// Mode codes, register indexes, reset values and shared word types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fss_pkg;

	// Mode codes carried on cmd_mode and mode_now
	localparam logic [2:0] MODE_OFF     = 3'd0;
	localparam logic [2:0] MODE_READY   = 3'd2;
	localparam logic [2:0] MODE_FEED    = 3'd3;
	localparam logic [2:0] MODE_RETRACT = 3'd4;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_STROKE  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MARGIN  = 4'd3;

	localparam int unsigned CFG_DATA_W = 20;

	// Register reset values
	localparam logic [19:0] RST_STROKE  = 20'd36864;
	localparam logic [15:0] RST_TIMEOUT = 16'd4000;
	localparam logic [19:0] RST_BACKOFF = 20'd20000;
	localparam logic [19:0] RST_MARGIN  = 20'd4000;

	localparam logic [15:0] STALL_MAX = 16'hFFFF;

	typedef struct packed {
		logic [19:0] stroke_counts;
		logic [15:0] jam_timeout_ticks;
		logic [19:0] jam_backoff_counts;
		logic [19:0] arrival_margin;
	} fss_cfg_t;

	typedef struct packed {
		logic               cmd_valid;
		logic [2:0]         cmd_mode;
		logic signed [31:0] encoder_position;
	} fss_item_t;

	typedef struct packed {
		logic signed [31:0] target_position;
		logic [2:0]         mode_now;
		logic               wheels_on;
		logic               jammed;
	} fss_result_t;

endpackage

// ===== hw/rtl/fss_in_if.sv =====
// ---------------------------------------------------------------------------
// Feeder stroke sequencer input channel
// Valid/ready channel carrying one control tick word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fss_in_if;
	logic               valid;
	logic               ready;
	logic               cmd_valid;
	logic [2:0]         cmd_mode;
	logic signed [31:0] encoder_position;

	modport source (output valid, output cmd_valid, output cmd_mode,
		output encoder_position, input ready);
	modport sink (input valid, input cmd_valid, input cmd_mode,
		input encoder_position, output ready);
endinterface

// ===== hw/rtl/fss_out_if.sv =====
// ---------------------------------------------------------------------------
// Feeder stroke sequencer output channel
// Valid/ready channel carrying one setpoint and status word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fss_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] target_position;
	logic [2:0]         mode_now;
	logic               wheels_on;
	logic               jammed;

	modport source (output valid, output target_position, output mode_now,
		output wheels_on, output jammed, input ready);
	modport sink (input valid, input target_position, input mode_now,
		input wheels_on, input jammed, output ready);
endinterface

// ===== hw/rtl/fss_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// Feeder stroke sequencer configuration registers
// Write-only register file for stroke, jam timeout, backoff and margin.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fss_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [fss_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [fss_pkg::CFG_DATA_W-1:0]   wr_data,
	output fss_pkg::fss_cfg_t                cfg
);
	import fss_pkg::*;

	fss_cfg_t cfg_q;

	// Load the addressed register; drop writes beyond the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stroke_counts      <= RST_STROKE;
			cfg_q.jam_timeout_ticks  <= RST_TIMEOUT;
			cfg_q.jam_backoff_counts <= RST_BACKOFF;
			cfg_q.arrival_margin     <= RST_MARGIN;
		end else if (wr_en) begin
			case (wr_index)
				CFG_STROKE:  cfg_q.stroke_counts      <= wr_data;
				CFG_TIMEOUT: cfg_q.jam_timeout_ticks  <= wr_data[15:0];
				CFG_BACKOFF: cfg_q.jam_backoff_counts <= wr_data;
				CFG_MARGIN:  cfg_q.arrival_margin     <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/fss_step.sv =====
// ---------------------------------------------------------------------------
// Feeder stroke sequencer step logic
// Mode, setpoint and jam state with the per-tick next-state logic.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "feeder_stroke_sequencer_defines.svh"

module fss_step (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  fss_pkg::fss_cfg_t    cfg,
	input  fss_pkg::fss_item_t   item,
	output fss_pkg::fss_result_t result
);
	import fss_pkg::*;

	logic [2:0]  mode_q;
	logic [2:0]  saved_q;
	logic        first_q;
	logic        jam_q;
	logic [15:0] stall_q;
	logic [31:0] target_q;

	logic [2:0]         mode_in;
	logic [2:0]         mode_d;
	logic [2:0]         saved_d;
	logic               first_d;
	logic               jam_d;
	logic [15:0]        stall_base;
	logic [15:0]        stall_d;
	logic [31:0]        target_d;
	logic signed [33:0] enc_x;
	logic signed [33:0] tgt_x;
	logic signed [33:0] lo_x;
	logic signed [33:0] hi_x;

	// Work out the state after one tick
	always_comb begin
		mode_in    = item.cmd_valid ? item.cmd_mode : mode_q;
		mode_d     = mode_in;
		saved_d    = saved_q;
		first_d    = first_q;
		jam_d      = jam_q;
		stall_base = stall_q;
		stall_d    = stall_q;
		target_d   = target_q;

		if (mode_in == MODE_FEED) begin
			if (first_q) begin
				first_d    = 1'b0;
				jam_d      = 1'b0;
				target_d   = target_q + {12'd0, cfg.stroke_counts};
				stall_base = '0;
			end
			stall_d = (stall_base != STALL_MAX) ? stall_base + 16'd1 : stall_base;
			if (stall_d > cfg.jam_timeout_ticks) begin
				first_d = 1'b1;
				jam_d   = 1'b1;
				mode_d  = MODE_RETRACT;
			end
		end else if (mode_in == MODE_RETRACT) begin
			if (first_q) begin
				first_d  = 1'b0;
				target_d = jam_q ?
					(item.encoder_position - {12'd0, cfg.jam_backoff_counts}) :
					(target_q - {12'd0, cfg.stroke_counts});
			end
		end else begin
			saved_d = mode_in;
		end

		// Arrival windows, compared exactly at 34 bits
		enc_x = {{2{item.encoder_position[31]}}, item.encoder_position};
		tgt_x = {{2{target_d[31]}}, target_d};
		lo_x  = tgt_x - $signed({14'd0, cfg.arrival_margin});
		hi_x  = tgt_x + $signed({14'd0, cfg.arrival_margin});

		if (mode_d == MODE_FEED && enc_x > lo_x) begin
			mode_d  = MODE_READY;
			first_d = 1'b1;
		end
		if (mode_d == MODE_RETRACT && enc_x < hi_x) begin
			mode_d  = jam_d ? MODE_FEED : saved_d;
			first_d = 1'b1;
		end
	end

	// Commit the state when a word moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_OFF;
			saved_q  <= MODE_OFF;
			first_q  <= 1'b1;
			jam_q    <= 1'b0;
			stall_q  <= '0;
			target_q <= '0;
		end else if (fire) begin
			mode_q   <= mode_d;
			saved_q  <= saved_d;
			first_q  <= first_d;
			jam_q    <= jam_d;
			stall_q  <= stall_d;
			target_q <= target_d;
		end
	end

	assign result.target_position = target_q;
	assign result.mode_now        = mode_q;
	assign result.wheels_on       = (saved_q != MODE_OFF);
	assign result.jammed          = jam_q;

	`FSS_ASSERT_IMP(a_saved_is_idle, clk, arst_n, 1'b1,
		saved_q != MODE_FEED && saved_q != MODE_RETRACT)
	`FSS_ASSERT_NXT(a_hold_without_fire, clk, arst_n, !fire,
		$stable(target_q) && $stable(mode_q) && $stable(jam_q))
	`FSS_ASSERT_IMP(a_jam_needs_fire, clk, arst_n, $rose(jam_q), $past(fire))
	`FSS_ASSERT_IMP(a_ready_clears_first, clk, arst_n,
		fire && mode_d == MODE_READY && mode_in == MODE_FEED, first_d)

endmodule

// ===== hw/rtl/feeder_stroke_sequencer.sv =====
// Feeder stroke sequencer: usage
// in_ch takes one control tick word per accepted handshake: an optional mode
// command (cmd_valid, cmd_mode) and the motor encoder position. out_ch gives
// exactly one result word per tick: the position setpoint, the mode after the
// tick, the wheels-on status and the jam flag.
// Configuration is written through cfg_wr_en / cfg_index / cfg_data while the
// block is idle, a rule for the user that the block does not enforce. Writes
// to an index past the arrival margin are dropped. An accepted tick waits
// in the input register; its result is valid on out_ch once it advances into
// the step registers. Throughput: one tick per cycle while out_ch does not
// stall; the only feedback path is a single compare-and-add step in fss_step.
// Reset clears mode and saved idle mode to wheels off, the setpoint, stall
// count and jam flag to zero, and reloads the register defaults.
// When the receiver stalls, the result word holds and, if the input register
// is empty, one further tick is taken into it; after that in_ch.ready drops.
// ---------------------------------------------------------------------------
// Feeder stroke sequencer top level
// Input register, step logic and result handshake for the feed motor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module feeder_stroke_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	fss_in_if.sink                         in_ch,
	fss_out_if.source                      out_ch,
	input  logic                           cfg_wr_en,
	input  logic [fss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fss_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fss_pkg::*;

	fss_cfg_t    cfg;
	fss_item_t   item_s1;
	logic        valid_s1;
	logic        out_valid_q;
	logic        advance;
	fss_result_t result;

	// Move the registered word on when the result slot is free or draining
	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	// Hold the accepted word in the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			item_s1.cmd_valid        <= in_ch.cmd_valid;
			item_s1.cmd_mode         <= in_ch.cmd_mode;
			item_s1.encoder_position <= in_ch.encoder_position;
		end
	end

	// Track the result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	fss_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_wr_en),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	fss_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.cfg    (cfg),
		.item   (item_s1),
		.result (result)
	);

	assign out_ch.valid           = out_valid_q;
	assign out_ch.target_position = result.target_position;
	assign out_ch.mode_now        = result.mode_now;
	assign out_ch.wheels_on       = result.wheels_on;
	assign out_ch.jammed          = result.jammed;

endmodule
